>>> hdl/srlp_pkg.sv
// Shared types and constants for the sensor response line parser.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package srlp_pkg;

   // Line limits and reading format
   localparam logic [5:0] MAX_LINE        = 6'd63;
   localparam logic [5:0] STATUS_LIMIT    = 6'd6;
   localparam int         FRACTION_DIGITS = 3;
   localparam logic [5:0] STORED_CHARS    = 6'd5;

   // Characters of interest
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_POINT = 8'h2E;

   // Register reset values
   localparam logic [15:0] TIMEOUT_RESET  = 16'd2000;
   localparam logic [5:0]  MAX_LEN_RESET  = 6'd32;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      CSR_TIMEOUT_MS   = 1'b0,
      CSR_MAX_LINE_LEN = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_STATUS   = 2'd0,
      KIND_READING  = 2'd1,
      KIND_TOO_LONG = 2'd2,
      KIND_TIMEOUT  = 2'd3
   } line_kind_type;

   typedef enum logic [3:0] {
      CODE_OK        = 4'd0,
      CODE_ERROR     = 4'd1,
      CODE_OVERVOLT  = 4'd2,
      CODE_UNDERVOLT = 4'd3,
      CODE_RESET     = 4'd4,
      CODE_READY     = 4'd5,
      CODE_SLEEP     = 4'd6,
      CODE_WAKE      = 4'd7,
      CODE_DONE      = 4'd8,
      CODE_UNKNOWN   = 4'd9
   } status_code_type;

   // Status tokens, first character in the low byte, zero padded
   localparam int TOKEN_COUNT = 9;
   localparam logic [39:0] TOKEN_TEXT [TOKEN_COUNT] = '{
      40'h00_00_4B_4F_2A,   // *OK
      40'h00_00_52_45_2A,   // *ER
      40'h00_00_56_4F_2A,   // *OV
      40'h00_00_56_55_2A,   // *UV
      40'h00_00_53_52_2A,   // *RS
      40'h00_00_45_52_2A,   // *RE
      40'h00_00_4C_53_2A,   // *SL
      40'h00_00_41_57_2A,   // *WA
      40'h45_4E_4F_44_2A    // *DONE
   };
   localparam logic [5:0] TOKEN_LEN [TOKEN_COUNT] = '{
      6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd3, 6'd5
   };

   // Powers of ten for scaling to thousandths
   localparam logic [31:0] POW10 [7] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000
   };

   typedef struct packed {
      logic            valid;
      line_kind_type   line_kind;
      status_code_type status_code;
      logic [31:0]     reading;
      logic [5:0]      line_length;
   } result_type;

endpackage

>>> hdl/srlp_token_match.sv
// Matches the stored characters of a status line against the token table.
// Depends on srlp_pkg.
`timescale 1ns / 1ps

module srlp_token_match (
   input  logic [39:0]               status_chars,
   input  logic [5:0]                char_count,
   output srlp_pkg::status_code_type status_code
);

   always_comb begin
      status_code = srlp_pkg::CODE_UNKNOWN;
      // reverse order so the first matching token wins
      for (int t = srlp_pkg::TOKEN_COUNT - 1; t >= 0; t--) begin
         if ((char_count == srlp_pkg::TOKEN_LEN[t]) &&
             (status_chars == srlp_pkg::TOKEN_TEXT[t])) begin
            status_code = srlp_pkg::status_code_type'(4'(t));
         end
      end
   end

endmodule

>>> hdl/srlp_line_engine.sv
// Line state and per-transaction update: gathers bytes, counts ticks and
// builds the result. Depends on srlp_pkg and srlp_token_match.
`timescale 1ns / 1ps

module srlp_line_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  srlp_pkg::op_type       op,
   input  logic [7:0]             data_byte,
   input  logic [15:0]            timeout_ms,
   input  logic [5:0]             max_line_len,
   output srlp_pkg::result_type   result
);

   logic [5:0]  char_count_ff,   char_count_in;
   logic [39:0] status_chars_ff, status_chars_in;
   logic        is_status_ff,    is_status_in;
   logic [31:0] accum_ff,        accum_in;
   logic        point_seen_ff,   point_seen_in;
   logic [5:0]  frac_digits_ff,  frac_digits_in;
   logic [15:0] tick_count_ff,   tick_count_in;

   srlp_pkg::status_code_type match_code;
   logic [15:0] tick_next;
   logic [5:0]  count_next;
   logic [5:0]  limit;
   logic        status_next;
   logic [31:0] scale;
   logic [31:0] scaled;
   logic        clear;

   srlp_token_match u_match (
      .status_chars (status_chars_ff),
      .char_count   (char_count_ff),
      .status_code  (match_code)
   );

   // missing fraction digits scale the reading up to thousandths
   always_comb begin
      if (frac_digits_ff >= 6'(srlp_pkg::FRACTION_DIGITS)) begin
         scale = 32'd1;
      end else begin
         scale = srlp_pkg::POW10[3'(6'(srlp_pkg::FRACTION_DIGITS) - frac_digits_ff)];
      end
   end
   // product kept modulo 2^32
   assign scaled = accum_ff * scale;

   assign tick_next   = (tick_count_ff == 16'hFFFF) ? tick_count_ff : tick_count_ff + 16'd1;
   assign count_next  = char_count_ff + 6'd1;
   assign status_next = is_status_ff ||
                        ((char_count_ff == 6'd0) && (data_byte == srlp_pkg::CHAR_STAR));

   always_comb begin
      limit = max_line_len;
      if (limit > srlp_pkg::MAX_LINE) begin
         limit = srlp_pkg::MAX_LINE;
      end
      if (status_next && (limit > srlp_pkg::STATUS_LIMIT)) begin
         limit = srlp_pkg::STATUS_LIMIT;
      end
   end

   always_comb begin
      result             = '0;
      result.line_kind   = srlp_pkg::KIND_STATUS;
      result.status_code = srlp_pkg::CODE_OK;
      clear              = 1'b0;

      char_count_in   = char_count_ff;
      status_chars_in = status_chars_ff;
      is_status_in    = is_status_ff;
      accum_in        = accum_ff;
      point_seen_in   = point_seen_ff;
      frac_digits_in  = frac_digits_ff;
      tick_count_in   = tick_count_ff;

      if (op == srlp_pkg::OP_TICK) begin
         tick_count_in = tick_next;
         if (tick_next > timeout_ms) begin
            result.valid       = 1'b1;
            result.line_kind   = srlp_pkg::KIND_TIMEOUT;
            result.line_length = char_count_ff;
            clear              = 1'b1;
         end
      end else if (data_byte == srlp_pkg::CHAR_CR) begin
         result.valid       = 1'b1;
         result.line_length = char_count_ff;
         if (is_status_ff) begin
            result.line_kind   = srlp_pkg::KIND_STATUS;
            result.status_code = match_code;
         end else begin
            result.line_kind = srlp_pkg::KIND_READING;
            result.reading   = scaled;
         end
         clear = 1'b1;
      end else begin
         is_status_in = status_next;
         if (char_count_ff < srlp_pkg::STORED_CHARS) begin
            status_chars_in[8 * char_count_ff[2:0] +: 8] = data_byte;
         end
         if (data_byte == srlp_pkg::CHAR_POINT) begin
            point_seen_in  = 1'b1;
            frac_digits_in = 6'd0;
         end else begin
            // value*10 + (byte - '0'), modulo 2^32
            accum_in = (accum_ff << 3) + (accum_ff << 1) + {24'd0, data_byte}
                       - {24'd0, srlp_pkg::CHAR_ZERO};
            if (point_seen_ff && (frac_digits_ff != 6'd63)) begin
               frac_digits_in = frac_digits_ff + 6'd1;
            end
         end
         char_count_in = count_next;
         if (count_next >= limit) begin
            result.valid       = 1'b1;
            result.line_kind   = srlp_pkg::KIND_TOO_LONG;
            result.line_length = count_next;
            clear              = 1'b1;
         end
      end

      if (clear) begin
         char_count_in   = '0;
         status_chars_in = '0;
         is_status_in    = 1'b0;
         accum_in        = '0;
         point_seen_in   = 1'b0;
         frac_digits_in  = '0;
         tick_count_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff   <= '0;
         status_chars_ff <= '0;
         is_status_ff    <= 1'b0;
         accum_ff        <= '0;
         point_seen_ff   <= 1'b0;
         frac_digits_ff  <= '0;
         tick_count_ff   <= '0;
      end else if (step) begin
         char_count_ff   <= char_count_in;
         status_chars_ff <= status_chars_in;
         is_status_ff    <= is_status_in;
         accum_ff        <= accum_in;
         point_seen_ff   <= point_seen_in;
         frac_digits_ff  <= frac_digits_in;
         tick_count_ff   <= tick_count_in;
      end
   end

endmodule

>>> hdl/sensor_response_line_parser.sv
// Top level of the sensor response line parser: handshakes, input and
// result registers, configuration registers. Depends on srlp_pkg and
// srlp_line_engine.
`timescale 1ns / 1ps

// Parses sensor reply lines from a stream of received bytes and 1 ms ticks.
// Each req_ transaction is one byte (op 0) or one tick (op 1); a carriage
// return closes a line and gives one rsp_ transaction: a status line ('*'
// first) with its token code, or a decimal reading in thousandths. A line
// that reaches its length limit gives a too-long result and is dropped, and
// a line older than timeout_ms ticks gives a timeout result. Throughput is
// one transaction per cycle while rsp_ is not stalled; an accepted
// transaction is held in the input register while the line engine processes
// it, and its result (if any) is then loaded into the result register,
// from which it shows on rsp_. Back-pressure on rsp_ stops the line engine,
// and req_ready then drops once the input register is also occupied. Write
// csr_ only while the block is idle.

module sensor_response_line_parser (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_line_kind,
   output logic [3:0]  rsp_status_code,
   output logic [31:0] rsp_reading,
   output logic [5:0]  rsp_line_length,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   // Input register
   logic        in_valid_ff;
   logic        in_op_ff;
   logic [7:0]  in_byte_ff;

   // Configuration
   logic [15:0] timeout_ms_ff;
   logic [5:0]  max_line_len_ff;

   // Result register
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff;
   logic [3:0]  out_code_ff;
   logic [31:0] out_reading_ff;
   logic [5:0]  out_length_ff;

   srlp_pkg::result_type result;
   logic advance;
   logic load_out;

   // engine moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign load_out  = advance && result.valid;
   assign csr_ready = 1'b1;

   srlp_line_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .op           (srlp_pkg::op_type'(in_op_ff)),
      .data_byte    (in_byte_ff),
      .timeout_ms   (timeout_ms_ff),
      .max_line_len (max_line_len_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_op;
         in_byte_ff <= req_data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ms_ff   <= srlp_pkg::TIMEOUT_RESET;
         max_line_len_ff <= srlp_pkg::MAX_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         case (srlp_pkg::csr_index_type'(csr_index))
            srlp_pkg::CSR_TIMEOUT_MS: begin
               timeout_ms_ff <= csr_wdata;
            end
            srlp_pkg::CSR_MAX_LINE_LEN: begin
               max_line_len_ff <= csr_wdata[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load_out) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_kind_ff    <= result.line_kind;
         out_code_ff    <= result.status_code;
         out_reading_ff <= result.reading;
         out_length_ff  <= result.line_length;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_line_kind   = out_kind_ff;
   assign rsp_status_code = out_code_ff;
   assign rsp_reading     = out_reading_ff;
   assign rsp_line_length = out_length_ff;

   // Checks

   // status code only carried by status lines
   a_code_only_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_kind != srlp_pkg::KIND_STATUS) |-> rsp_status_code == 4'd0)
      else $error("status code set on a non-status result");

   // reading only carried by reading lines
   a_reading_only_reading: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_line_kind != srlp_pkg::KIND_READING) |-> rsp_reading == 32'd0)
      else $error("reading set on a non-reading result");

   // a stalled transaction stays in the input register
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_op_ff))
      else $error("input register lost a stalled transaction");

   // a result is never loaded over one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load_out |-> !out_valid_ff || rsp_ready)
      else $error("result register overwritten");

endmodule

>>> verif/srlp_line_checker.sv
// Checker for the sensor response line parser: watches the req_, rsp_ and
// csr_ channels, predicts every result and compares the results in order.
// Depends on srlp_pkg.
`timescale 1ns / 1ps

module srlp_line_checker (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_op,
   input  logic [7:0]  req_data_byte,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_line_kind,
   input  logic [3:0]  rsp_status_code,
   input  logic [31:0] rsp_reading,
   input  logic [5:0]  rsp_line_length,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,

   output int unsigned faults,
   output int unsigned outstanding
);

   typedef struct packed {
      srlp_pkg::line_kind_type   kind;
      srlp_pkg::status_code_type code;
      logic [31:0]               reading;
      logic [5:0]                length;
   } parsed_line_type;

   parsed_line_type awaited_lines[$];
   parsed_line_type oldest;

   // Predicted parser state and register copies
   logic [15:0] cfg_timeout;
   logic [5:0]  cfg_max_len;
   logic [5:0]  line_chars;
   logic [39:0] lead_chars;
   logic        status_line;
   logic [31:0] reading_acc;
   logic        point_found;
   logic [5:0]  fraction_count;
   logic [15:0] ms_since_result;

   task automatic report_fault(input string text);
      $display("srlp check at %0t ns: %s", $time, text);
      faults++;
   endtask

   task automatic drop_line();
      line_chars      = '0;
      lead_chars      = '0;
      status_line     = 1'b0;
      reading_acc     = '0;
      point_found     = 1'b0;
      fraction_count  = '0;
      ms_since_result = '0;
   endtask

   task automatic expect_line(input srlp_pkg::line_kind_type kind,
                              input srlp_pkg::status_code_type code,
                              input logic [31:0] value);
      parsed_line_type entry;
      entry.kind    = kind;
      entry.code    = code;
      entry.reading = value;
      entry.length  = line_chars;
      awaited_lines.push_back(entry);
      drop_line();
   endtask

   function automatic srlp_pkg::status_code_type token_code(input logic [5:0] count,
                                                            input logic [39:0] chars);
      logic [39:0]               text;
      srlp_pkg::status_code_type code;
      // first character leftmost, so the line reads as written
      text = {chars[7:0], chars[15:8], chars[23:16], chars[31:24], chars[39:32]};
      code = srlp_pkg::CODE_UNKNOWN;
      if (count == 6'd5) begin
         if (text == "*DONE")
            code = srlp_pkg::CODE_DONE;
      end else if (count == 6'd3) begin
         case (text[39:16])
            "*OK":   code = srlp_pkg::CODE_OK;
            "*ER":   code = srlp_pkg::CODE_ERROR;
            "*OV":   code = srlp_pkg::CODE_OVERVOLT;
            "*UV":   code = srlp_pkg::CODE_UNDERVOLT;
            "*RS":   code = srlp_pkg::CODE_RESET;
            "*RE":   code = srlp_pkg::CODE_READY;
            "*SL":   code = srlp_pkg::CODE_SLEEP;
            "*WA":   code = srlp_pkg::CODE_WAKE;
            default: code = srlp_pkg::CODE_UNKNOWN;
         endcase
      end
      return code;
   endfunction

   task automatic take_transaction(input logic op, input logic [7:0] b);
      logic [31:0] value;
      logic [5:0]  limit;
      int          d;
      if (op == srlp_pkg::OP_TICK) begin
         if (ms_since_result != 16'hFFFF)
            ms_since_result = ms_since_result + 16'd1;
         if (ms_since_result > cfg_timeout)
            expect_line(srlp_pkg::KIND_TIMEOUT, srlp_pkg::CODE_OK, '0);
      end else if (b == srlp_pkg::CHAR_CR) begin
         if (status_line) begin
            expect_line(srlp_pkg::KIND_STATUS, token_code(line_chars, lead_chars), '0);
         end else begin
            value = reading_acc;
            for (d = fraction_count; d < srlp_pkg::FRACTION_DIGITS; d++)
               value = value * 32'd10;
            expect_line(srlp_pkg::KIND_READING, srlp_pkg::CODE_OK, value);
         end
      end else begin
         if (line_chars == 6'd0 && b == srlp_pkg::CHAR_STAR)
            status_line = 1'b1;
         if (line_chars < srlp_pkg::STORED_CHARS)
            lead_chars[line_chars * 8 +: 8] = b;
         if (b == srlp_pkg::CHAR_POINT) begin
            point_found    = 1'b1;
            fraction_count = '0;
         end else begin
            // any byte counts as a digit, wrapping at 32 bits
            reading_acc = reading_acc * 32'd10 + ({24'd0, b} - {24'd0, srlp_pkg::CHAR_ZERO});
            if (point_found && fraction_count < 6'd63)
               fraction_count = fraction_count + 6'd1;
         end
         line_chars = line_chars + 6'd1;
         limit = (cfg_max_len > srlp_pkg::MAX_LINE) ? srlp_pkg::MAX_LINE : cfg_max_len;
         if (status_line && limit > srlp_pkg::STATUS_LIMIT)
            limit = srlp_pkg::STATUS_LIMIT;
         if (line_chars >= limit)
            expect_line(srlp_pkg::KIND_TOO_LONG, srlp_pkg::CODE_OK, '0);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited_lines.delete();
         drop_line();
         cfg_timeout = srlp_pkg::TIMEOUT_RESET;
         cfg_max_len = srlp_pkg::MAX_LEN_RESET;
         faults      = 0;
         outstanding <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_lines.size() == 0) begin
               report_fault($sformatf("unexpected result kind %0d code %0d reading %0d len %0d",
                  rsp_line_kind, rsp_status_code, rsp_reading, rsp_line_length));
            end else begin
               oldest = awaited_lines.pop_front();
               if (rsp_line_kind !== oldest.kind)
                  report_fault($sformatf("line_kind got %0d want %0d",
                     rsp_line_kind, oldest.kind));
               if (rsp_status_code !== oldest.code)
                  report_fault($sformatf("status_code got %0d want %0d",
                     rsp_status_code, oldest.code));
               if (rsp_reading !== oldest.reading)
                  report_fault($sformatf("reading got %0d want %0d",
                     rsp_reading, oldest.reading));
               if (rsp_line_length !== oldest.length)
                  report_fault($sformatf("line_length got %0d want %0d",
                     rsp_line_length, oldest.length));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == srlp_pkg::CSR_TIMEOUT_MS)
               cfg_timeout = csr_wdata;
            else
               cfg_max_len = csr_wdata[5:0];
         end
         if (req_valid && req_ready)
            take_transaction(req_op, req_data_byte);
         outstanding <= awaited_lines.size();
      end
   end

endmodule

>>> verif/sensor_response_line_parser_test.sv
// Testbench top for the sensor response line parser: clock, reset, stimulus
// and verdict. Depends on srlp_pkg, srlp_line_checker and the block itself.
`timescale 1ns / 1ps

module sensor_response_line_parser_test;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 12;     // a result passes the input and result registers after acceptance
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned QUIET_TICKS   = 40;     // ticks taken with timeouts switched off

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic        req_op        = srlp_pkg::OP_BYTE;
   logic [7:0]  req_data_byte = 8'd0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_line_kind;
   logic [3:0]  rsp_status_code;
   logic [31:0] rsp_reading;
   logic [5:0]  rsp_line_length;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = srlp_pkg::CSR_TIMEOUT_MS;
   logic [15:0] csr_wdata = 16'd0;

   int unsigned faults;
   int unsigned outstanding;

   // Stimulus knobs. stall_pct and hold_go are read by the receiver process,
   // so they are only ever changed with nonblocking assignments.
   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   logic        hold_go     = 1'b0;
   logic        hold_go_q   = 1'b0;
   int unsigned hold_left   = 0;
   int unsigned cur_timeout = srlp_pkg::TIMEOUT_RESET;
   int unsigned items_sent  = 0;
   int unsigned cycle_count = 0;

   string status_tokens [9] = '{"*OK", "*ER", "*OV", "*UV", "*RS", "*RE", "*SL", "*WA",
                                "*DONE"};
   string token_letters = "OKERVUSLWADN";

   sensor_response_line_parser uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_kind   (rsp_line_kind),
      .rsp_status_code (rsp_status_code),
      .rsp_reading     (rsp_reading),
      .rsp_line_length (rsp_line_length),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   srlp_line_checker line_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_line_kind   (rsp_line_kind),
      .rsp_status_code (rsp_status_code),
      .rsp_reading     (rsp_reading),
      .rsp_line_length (rsp_line_length),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .faults          (faults),
      .outstanding     (outstanding)
   );

   // 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sensor_response_line_parser: mismatch");
         $finish;
      end
   end

   // Result side. Random stalls at stall_pct, plus one long hold-off counted
   // here from the rising edge of hold_go; meanwhile the sender keeps going,
   // so the block backs up and drops req_ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_go_q <= 1'b0;
         hold_left <= 0;
      end else begin
         hold_go_q <= hold_go;
         if (hold_go && !hold_go_q) begin
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // One req_ transaction. Valid is only lowered when a gap is taken, so back
   // to back transactions never see valid dropped and raised in one step.
   task automatic send_item(input logic op, input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(srlp_pkg::OP_TICK, 8'($urandom_range(255)));
   endtask

   // A byte of a line, now and then with a tick slipped in before it
   task automatic send_line_char(input logic [7:0] c);
      if ($urandom_range(99) < 4)
         send_tick();
      send_item(srlp_pkg::OP_BYTE, c);
   endtask

   task automatic send_plain(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         send_item(srlp_pkg::OP_BYTE, s[i]);
   endtask

   task automatic send_random_line();
      int unsigned pick, n, i, r, burst;
      logic [7:0]  c;
      string       word;
      pick = $urandom_range(99);
      if (pick < 30) begin
         // status lines: mostly real tokens, otherwise near misses and junk
         if ($urandom_range(3) != 0) begin
            word = status_tokens[$urandom_range(8)];
            for (i = 0; i < word.len(); i++)
               send_line_char(word[i]);
         end else begin
            send_line_char(srlp_pkg::CHAR_STAR);
            n = $urandom_range(6);
            for (i = 0; i < n; i++) begin
               if ($urandom_range(1) == 0)
                  c = token_letters[$urandom_range(11)];
               else
                  c = 8'($urandom_range(32, 126));
               send_line_char(c);
            end
         end
         if ($urandom_range(19) != 0)
            send_line_char(srlp_pkg::CHAR_CR);
      end else if (pick < 75) begin
         // readings, mostly short, a few long enough to hit the length limit
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 70) : $urandom_range(10);
         for (i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 82)
               c = srlp_pkg::CHAR_ZERO + 8'($urandom_range(9));
            else if (r < 92)
               c = srlp_pkg::CHAR_POINT;
            else
               c = 8'($urandom_range(255));
            send_line_char(c);
         end
         if ($urandom_range(19) != 0)
            send_line_char(srlp_pkg::CHAR_CR);
      end else if (pick < 88) begin
         // tick bursts sized to the current timeout
         burst = (cur_timeout < 38) ? cur_timeout + 2 : 40;
         n = $urandom_range(1, burst);
         for (i = 0; i < n; i++)
            send_tick();
      end else begin
         // line noise, any byte value
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++)
            send_item(srlp_pkg::OP_BYTE, 8'($urandom_range(255)));
      end
   endtask

   // Wait until every predicted result has been taken, then let anything
   // without a result clear the pipeline.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Upper write data bits of max_line_len are don't-care; fill them randomly.
   task automatic set_registers(input logic [15:0] timeout, input logic [5:0] max_len);
      logic [9:0] junk;
      junk = 10'($urandom_range(1023));
      drain();
      write_csr(srlp_pkg::CSR_TIMEOUT_MS, timeout);
      write_csr(srlp_pkg::CSR_MAX_LINE_LEN, {junk, max_len});
      cur_timeout = timeout;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned send_idle,
                             input int unsigned recv_stall);
      int unsigned target;
      target    = items_sent + count;
      idle_pct  = send_idle;
      stall_pct <= recv_stall;
      while (items_sent < target)
         send_random_line();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, reset register values
      send_plain("*OK");
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);
      send_plain("*DONE");
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);   // empty line reads as zero
      send_plain("1.2.34");                              // only the last point counts
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);
      send_item(srlp_pkg::OP_BYTE, 8'hFF);               // non-digits still accumulate
      send_item(srlp_pkg::OP_BYTE, 8'h00);
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);
      send_item(srlp_pkg::OP_TICK, 8'hFF);
      send_item(srlp_pkg::OP_TICK, 8'h00);
      send_plain("*XY");                                 // unknown status
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);

      // Timeout on every tick, shortest sensible line
      set_registers(16'd0, 6'd2);
      run_random(150, 0, 0);

      // Longest line, sender idling
      set_registers(16'd30, 6'd63);
      run_random(250, 60, 0);

      // Receiver stalling
      set_registers(16'd12, 6'd20);
      run_random(250, 0, 60);

      // Limits below two flag the first character; timeouts first switched off, then at 5
      set_registers(16'hFFFF, 6'd0);
      run_random(100, 7, 7);
      set_registers(16'd5, 6'd1);
      run_random(100, 7, 7);

      // Long receiver hold-off with the sender pushing short lines
      set_registers(srlp_pkg::TIMEOUT_RESET, srlp_pkg::MAX_LEN_RESET);
      idle_pct  = 0;
      stall_pct <= 0;
      hold_go   <= 1'b1;
      repeat (12) begin
         send_item(srlp_pkg::OP_BYTE, "7");
         send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);
      end
      hold_go <= 1'b0;
      run_random(150, 0, 0);

      set_registers(16'd25, 6'd40);
      run_random(350, 7, 7);

      // With the timeout at its ceiling nothing fires, then a lower timeout
      // makes the very next tick time out the open line.
      set_registers(16'hFFFF, 6'd32);
      idle_pct  = 0;
      stall_pct <= 0;
      send_plain("12");
      repeat (QUIET_TICKS) send_item(srlp_pkg::OP_TICK, 8'($urandom_range(255)));
      set_registers(16'd20, 6'd32);
      send_tick();
      send_plain("*RE");
      send_item(srlp_pkg::OP_BYTE, srlp_pkg::CHAR_CR);

      drain();
      if (faults == 0 && outstanding == 0)
         $display("sensor_response_line_parser: match");
      else
         $display("sensor_response_line_parser: mismatch");
      $finish;
   end

endmodule

>>> sim.f
hdl/srlp_pkg.sv
hdl/srlp_token_match.sv
hdl/srlp_line_engine.sv
hdl/sensor_response_line_parser.sv
verif/srlp_line_checker.sv
verif/sensor_response_line_parser_test.sv
